/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RMJ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define RMJ_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/rmj_pkg.sv */
// types, constants and step functions of the radar jacobian pipeline
// no dependencies; used by radar_measurement_jacobian
`timescale 1ns / 1ps
`default_nettype none

package rmj_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 33;
  // mag, product, sum, root, first divide, multiply, setup, second divide, output
  localparam int unsigned PIPE_LAT   = 3 + SQRT_STEPS + DIV_STEPS + 2 + DIV_STEPS + 1;
  localparam logic [15:0] MIN_RANGE_SQ_RST = 16'd7;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } meas_in_t;

  typedef struct packed {
    logic signed [31:0] drange_dpx;
    logic signed [31:0] drange_dpy;
    logic signed [31:0] dbearing_dpx;
    logic signed [31:0] dbearing_dpy;
    logic signed [31:0] drate_dpx;
    logic signed [31:0] drate_dpy;
    logic               too_close;
  } jac_out_t;

  // sign-magnitude operands
  typedef struct packed {
    logic [31:0] pxm;
    logic [31:0] pym;
    logic [31:0] vxm;
    logic [31:0] vym;
    logic        npx;
    logic        npy;
    logic        nvx;
    logic        nvy;
  } mag_t;

  // raw products
  typedef struct packed {
    logic [63:0] pxx;
    logic [63:0] pyy;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [31:0] pxm;
    logic [31:0] pym;
    logic        npx;
    logic        npy;
    logic        sa;
    logic        sb;
  } prod_t;

  // square root iteration
  typedef struct packed {
    logic [63:0] op;
    logic [63:0] res;
    logic [31:0] pxm;
    logic [31:0] pym;
    logic [63:0] mc;
    logic        npx;
    logic        npy;
    logic        nc;
    logic        near;
  } sqrt_t;

  // first divide: px/r, py/r, c/r
  typedef struct packed {
    logic [31:0] r;
    logic [65:0] ax;
    logic [65:0] ay;
    logic [65:0] aw;
    logic        npx;
    logic        npy;
    logic        nc;
    logic        near;
  } divc_t;

  // unit vector times rate term
  typedef struct packed {
    logic [31:0] r;
    logic [16:0] ux;
    logic [16:0] uy;
    logic [49:0] nrx;
    logic [49:0] nry;
    logic        npx;
    logic        npy;
    logic        nc;
    logic        near;
  } mulw_t;

  // second divide: bearing and rate terms over r
  typedef struct packed {
    logic [31:0] r;
    logic [16:0] ux;
    logic [16:0] uy;
    logic [65:0] abx;
    logic [65:0] aby;
    logic [65:0] arx;
    logic [65:0] ary;
    logic        obx;
    logic        oby;
    logic        orx;
    logic        ory;
    logic        npx;
    logic        npy;
    logic        nc;
    logic        near;
  } dive_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // one digit of the bitwise integer square root, returns {op, res}
  function automatic logic [127:0] sqrt_step(logic [63:0] op, logic [63:0] res,
                                             logic [4:0] k);
    logic [63:0] one;
    logic [63:0] t;
    logic [63:0] op_n;
    logic [63:0] res_n;
    one = 64'd1 << (7'd62 - {1'b0, k, 1'b0});
    t   = res + one;
    if (op >= t) begin
      op_n  = op - t;
      res_n = (res >> 1) + one;
    end else begin
      op_n  = op;
      res_n = res >> 1;
    end
    return {op_n, res_n};
  endfunction

  // one restoring divide step on {remainder, numerator/quotient}
  function automatic logic [65:0] div_step(logic [65:0] acc, logic [31:0] d);
    logic [65:0] sh;
    logic [32:0] up;
    sh = {acc[64:0], 1'b0};
    up = sh[65:33];
    if (up >= {1'b0, d}) begin
      sh[65:33] = up - {1'b0, d};
      sh[0]     = 1'b1;
    end
    return sh;
  endfunction

  function automatic divc_t divc_step(divc_t x);
    divc_t y;
    y    = x;
    y.ax = div_step(x.ax, x.r);
    y.ay = div_step(x.ay, x.r);
    y.aw = div_step(x.aw, x.r);
    return y;
  endfunction

  function automatic dive_t dive_step(dive_t x);
    dive_t y;
    y     = x;
    y.abx = div_step(x.abx, x.r);
    y.aby = div_step(x.aby, x.r);
    y.arx = div_step(x.arx, x.r);
    y.ary = div_step(x.ary, x.r);
    return y;
  endfunction

  // apply sign and clamp to 32-bit two's complement
  function automatic logic [31:0] sat32(logic neg, logic big, logic [31:0] mag);
    if (big || mag[31]) begin
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return neg ? (~mag + 32'd1) : mag;
  endfunction

endpackage

`default_nettype wire

/* rtl/radar_measurement_jacobian.sv */
// radar measurement jacobian: deep pipeline from state to partial derivatives
// depends on rmj_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Usage
//   Input channel: drive in_i and pulse start; a beat is taken at every edge
//   with start high and busy low. busy is always low, so one state beat can
//   enter every cycle.
//   Result channel: res_valid_o is high for one cycle with res_o holding the
//   six jacobian terms and the too_close flag. Results leave in input order.
//   The receiver cannot stall; every result is taken the cycle it shows.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_data_i writes the squared
//   range threshold (unsigned Q0.16); cfg_ready_o is always high. Write
//   it only while no beats are in flight.
//   Stages: 3 front stages, 32 square root stages, 33 first divide
//   stages, 2 multiply and setup stages, 33 second divide stages and the
//   output register.
//   Throughput: one beat per cycle.
//   Reset: clears the in-flight valid bits and loads the threshold with 7.
module radar_measurement_jacobian
  import rmj_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire meas_in_t    in_i,
  output logic             res_valid_o,
  output jac_out_t         res_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned SqrtLastIdx = 2 + SQRT_STEPS;

  logic [15:0]         min_range_sq_q;
  logic [PIPE_LAT-1:0] vld_q;
  logic [PIPE_LAT-1:0] vld_d;
  logic                accept;

  mag_t     s1_d, s1_q;
  prod_t    s2_d, s2_q;
  sqrt_t    s3_d, s3_q;
  sqrt_t    sq_d [SQRT_STEPS];
  sqrt_t    sq_q [SQRT_STEPS];
  divc_t    dv_init;
  divc_t    dv_d [DIV_STEPS];
  divc_t    dv_q [DIV_STEPS];
  mulw_t    d1_d, d1_q;
  dive_t    d2_d, d2_q;
  dive_t    ev_d [DIV_STEPS];
  dive_t    ev_q [DIV_STEPS];
  jac_out_t out_d, out_q;

  // handshakes
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_sq_q <= MIN_RANGE_SQ_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_range_sq_q <= cfg_data_i;
    end
  end

  // valid bits ride along with the data
  assign vld_d = {vld_q[PIPE_LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: sign-magnitude split
  always_comb begin
    s1_d.pxm = mag32(in_i.pos_x);
    s1_d.pym = mag32(in_i.pos_y);
    s1_d.vxm = mag32(in_i.vel_x);
    s1_d.vym = mag32(in_i.vel_y);
    s1_d.npx = in_i.pos_x[31];
    s1_d.npy = in_i.pos_y[31];
    s1_d.nvx = in_i.vel_x[31];
    s1_d.nvy = in_i.vel_y[31];
  end

  // stage 2: squares and cross products
  always_comb begin
    s2_d.pxx = s1_q.pxm * s1_q.pxm;
    s2_d.pyy = s1_q.pym * s1_q.pym;
    s2_d.ma  = s1_q.vxm * s1_q.pym;
    s2_d.mb  = s1_q.vym * s1_q.pxm;
    s2_d.pxm = s1_q.pxm;
    s2_d.pym = s1_q.pym;
    s2_d.npx = s1_q.npx;
    s2_d.npy = s1_q.npy;
    s2_d.sa  = s1_q.nvx ^ s1_q.npy;
    s2_d.sb  = s1_q.nvy ^ s1_q.npx;
  end

  // stage 3: squared range, cross term, near-origin check
  always_comb begin
    s3_d.op   = s2_q.pxx + s2_q.pyy;
    s3_d.res  = '0;
    s3_d.pxm  = s2_q.pxm;
    s3_d.pym  = s2_q.pym;
    s3_d.npx  = s2_q.npx;
    s3_d.npy  = s2_q.npy;
    s3_d.near = (s3_d.op == 64'd0) ||
                (s3_d.op < (64'(min_range_sq_q) << FRAC_BITS));
    if (s2_q.sa != s2_q.sb) begin
      s3_d.mc = s2_q.ma + s2_q.mb;
      s3_d.nc = s2_q.sa;
    end else if (s2_q.ma >= s2_q.mb) begin
      s3_d.mc = s2_q.ma - s2_q.mb;
      s3_d.nc = s2_q.sa;
    end else begin
      s3_d.mc = s2_q.mb - s2_q.ma;
      s3_d.nc = !s2_q.sa;
    end
  end

  // square root, one result bit per stage
  always_comb begin
    sq_d[0] = s3_q;
    {sq_d[0].op, sq_d[0].res} = sqrt_step(s3_q.op, s3_q.res, 5'd0);
    for (int k = 1; k < SQRT_STEPS; k++) begin
      sq_d[k] = sq_q[k-1];
      {sq_d[k].op, sq_d[k].res} = sqrt_step(sq_q[k-1].op, sq_q[k-1].res, 5'(k));
    end
  end

  // first divide: unit vector and rate term over r
  always_comb begin
    dv_init.r    = sq_q[SQRT_STEPS-1].res[31:0];
    dv_init.ax   = 66'(sq_q[SQRT_STEPS-1].pxm) << FRAC_BITS;
    dv_init.ay   = 66'(sq_q[SQRT_STEPS-1].pym) << FRAC_BITS;
    dv_init.aw   = 66'(sq_q[SQRT_STEPS-1].mc);
    dv_init.npx  = sq_q[SQRT_STEPS-1].npx;
    dv_init.npy  = sq_q[SQRT_STEPS-1].npy;
    dv_init.nc   = sq_q[SQRT_STEPS-1].nc;
    dv_init.near = sq_q[SQRT_STEPS-1].near;
    dv_d[0] = divc_step(dv_init);
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_d[k] = divc_step(dv_q[k-1]);
    end
  end

  // multiply unit vector by rate term
  always_comb begin
    d1_d.r    = dv_q[DIV_STEPS-1].r;
    d1_d.ux   = dv_q[DIV_STEPS-1].ax[16:0];
    d1_d.uy   = dv_q[DIV_STEPS-1].ay[16:0];
    d1_d.nrx  = dv_q[DIV_STEPS-1].ay[16:0] * dv_q[DIV_STEPS-1].aw[32:0];
    d1_d.nry  = dv_q[DIV_STEPS-1].ax[16:0] * dv_q[DIV_STEPS-1].aw[32:0];
    d1_d.npx  = dv_q[DIV_STEPS-1].npx;
    d1_d.npy  = dv_q[DIV_STEPS-1].npy;
    d1_d.nc   = dv_q[DIV_STEPS-1].nc;
    d1_d.near = dv_q[DIV_STEPS-1].near;
  end

  // second divide setup: overflow checks against r * 2^31
  always_comb begin
    d2_d.r    = d1_q.r;
    d2_d.ux   = d1_q.ux;
    d2_d.uy   = d1_q.uy;
    d2_d.abx  = 66'(d1_q.uy) << FRAC_BITS;
    d2_d.aby  = 66'(d1_q.ux) << FRAC_BITS;
    d2_d.arx  = 66'(d1_q.nrx);
    d2_d.ary  = 66'(d1_q.nry);
    d2_d.obx  = (64'(d1_q.uy) << FRAC_BITS) >= (64'(d1_q.r) << 31);
    d2_d.oby  = (64'(d1_q.ux) << FRAC_BITS) >= (64'(d1_q.r) << 31);
    d2_d.orx  = 64'(d1_q.nrx) >= (64'(d1_q.r) << 31);
    d2_d.ory  = 64'(d1_q.nry) >= (64'(d1_q.r) << 31);
    d2_d.npx  = d1_q.npx;
    d2_d.npy  = d1_q.npy;
    d2_d.nc   = d1_q.nc;
    d2_d.near = d1_q.near;
  end

  // second divide
  always_comb begin
    ev_d[0] = dive_step(d2_q);
    for (int k = 1; k < DIV_STEPS; k++) begin
      ev_d[k] = dive_step(ev_q[k-1]);
    end
  end

  // sign, saturation and near-origin override
  always_comb begin
    out_d.drange_dpx   = sat32(ev_q[DIV_STEPS-1].npx, 1'b0,
                               32'(ev_q[DIV_STEPS-1].ux));
    out_d.drange_dpy   = sat32(ev_q[DIV_STEPS-1].npy, 1'b0,
                               32'(ev_q[DIV_STEPS-1].uy));
    out_d.dbearing_dpx = sat32(!ev_q[DIV_STEPS-1].npy,
                               ev_q[DIV_STEPS-1].obx | ev_q[DIV_STEPS-1].abx[32],
                               ev_q[DIV_STEPS-1].abx[31:0]);
    out_d.dbearing_dpy = sat32(ev_q[DIV_STEPS-1].npx,
                               ev_q[DIV_STEPS-1].oby | ev_q[DIV_STEPS-1].aby[32],
                               ev_q[DIV_STEPS-1].aby[31:0]);
    out_d.drate_dpx    = sat32(ev_q[DIV_STEPS-1].npy ^ ev_q[DIV_STEPS-1].nc,
                               ev_q[DIV_STEPS-1].orx | ev_q[DIV_STEPS-1].arx[32],
                               ev_q[DIV_STEPS-1].arx[31:0]);
    out_d.drate_dpy    = sat32(ev_q[DIV_STEPS-1].npx ~^ ev_q[DIV_STEPS-1].nc,
                               ev_q[DIV_STEPS-1].ory | ev_q[DIV_STEPS-1].ary[32],
                               ev_q[DIV_STEPS-1].ary[31:0]);
    out_d.too_close    = 1'b0;
    if (ev_q[DIV_STEPS-1].near) begin
      out_d           = '0;
      out_d.too_close = 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    s3_q  <= s3_d;
    sq_q  <= sq_d;
    dv_q  <= dv_d;
    d1_q  <= d1_d;
    d2_q  <= d2_d;
    ev_q  <= ev_d;
    out_q <= out_d;
  end

  assign res_valid_o = vld_q[PIPE_LAT-1];
  assign res_o       = out_q;

  // checks
  `RMJ_ASSERT(a_res_follows_start, res_valid_o |-> $past(accept, PIPE_LAT),
              "result without matching start beat")
  `RMJ_ASSERT(a_root_nonzero,
              (vld_q[SqrtLastIdx] && !sq_q[SQRT_STEPS-1].near) |->
              (sq_q[SQRT_STEPS-1].res != 64'd0),
              "zero range root reached the divider")
  `RMJ_ASSERT_NEVER(a_close_zeroes,
                    res_valid_o && res_o.too_close &&
                    ((res_o.drange_dpx != 0) || (res_o.drange_dpy != 0) ||
                     (res_o.dbearing_dpx != 0) || (res_o.dbearing_dpy != 0) ||
                     (res_o.drate_dpx != 0) || (res_o.drate_dpy != 0)),
                    "near-origin result carries nonzero terms")
  `RMJ_ASSERT(a_unit_bound,
              (res_valid_o && !res_o.too_close) |->
              ((res_o.drange_dpx <= 32'sd65536) && (res_o.drange_dpx >= -32'sd65536) &&
               (res_o.drange_dpy <= 32'sd65536) && (res_o.drange_dpy >= -32'sd65536)),
              "unit vector term above one")

endmodule

`default_nettype wire
